FILE: rtl/ethernet_vlan_ipv4_l4_header_parser_defines.svh
// Assertion macros shared by the header parser checker.
// No dependencies; include by bare file name.
`ifndef ETHERNET_VLAN_IPV4_L4_HEADER_PARSER_DEFINES_SVH
`define ETHERNET_VLAN_IPV4_L4_HEADER_PARSER_DEFINES_SVH

// Clocked assertion, off while reset is asserted.
`define EVLHP_ASSERT_CLK(name, clk, rstn, prop) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("header parser assertion failed");

// Clocked assertion that also holds through reset.
`define EVLHP_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("header parser reset assertion failed");

`endif

FILE: rtl/evlhp_pkg.sv
// Types and constants of the Ethernet/VLAN/IPv4/L4 header parser.
// No dependencies.
package evlhp_pkg;

    localparam logic [15:0] ETH_IPV4  = 16'h0800;
    localparam logic [15:0] ETH_VLAN  = 16'h8100;
    localparam logic [7:0]  PROTO_TCP = 8'h06;
    localparam logic [7:0]  PROTO_UDP = 8'h11;

    localparam logic [15:0] HTTP_PORT_RESET  = 16'd80;
    localparam logic [7:0]  HTTP_FLAGS_RESET = 8'h18;

    localparam logic [5:0] OFFSET_MAX = 6'd63;

    localparam logic CFG_HTTP_PORT  = 1'b0;
    localparam logic CFG_HTTP_FLAGS = 1'b1;

    localparam logic [2:0] ST_OTHER_TYPE = 3'd0;
    localparam logic [2:0] ST_IPV4_OTHER = 3'd1;
    localparam logic [2:0] ST_TCP        = 3'd2;
    localparam logic [2:0] ST_HTTP       = 3'd3;
    localparam logic [2:0] ST_UDP        = 3'd4;
    localparam logic [2:0] ST_TRUNCATED  = 3'd5;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
    } in_word_t;

    typedef struct packed {
        logic [15:0] ether_type;
        logic        vlan_tagged;
        logic [2:0]  vlan_priority;
        logic        vlan_cfi;
        logic [11:0] vlan_id;
        logic [7:0]  ip_protocol;
        logic [31:0] source_address;
        logic [31:0] destination_address;
        logic [15:0] source_port;
        logic [15:0] destination_port;
        logic [7:0]  tcp_flag_bits;
        logic [2:0]  status;
    } out_word_t;

    typedef struct packed {
        logic [15:0] outer_type;
        logic [15:0] tag_word;
        logic [15:0] inner_type;
        logic [7:0]  protocol;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  flags;
    } frame_fields_t;

endpackage

FILE: rtl/ethernet_vlan_ipv4_l4_header_parser.sv
// Ethernet/802.1Q/IPv4/TCP-UDP header parser, top level.
// Depends on evlhp_pkg, evlhp_field_capture and evlhp_summary.
//
//   port group | dir | word          | moves when
//   s_         | in  | in_word_t     | s_valid && s_ready, one frame byte
//   m_         | out | out_word_t    | m_valid && m_ready, one summary per frame
//   cfg_       | in  | index + data  | cfg_wr_en high, no wait
//
// One byte per cycle; the summary shows in the cycle after the last byte.
// The offset compare and field load of the capture registers set that rate.
// A held summary stalls only the next last byte; other bytes still go in.
// Synchronous active-low reset clears the frame state and the output valid.
module ethernet_vlan_ipv4_l4_header_parser (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  evlhp_pkg::in_word_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output evlhp_pkg::out_word_t m_data,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_index,
    input  logic [15:0]          cfg_wdata
);
    import evlhp_pkg::*;

    logic          accept;
    frame_fields_t fields_next;
    logic [6:0]    byte_count;
    out_word_t     summary;
    logic          m_valid_reg;
    out_word_t     m_data_reg;
    logic [15:0]   http_port_reg;
    logic [7:0]    http_flags_reg;

    assign s_ready = m_ready || !m_valid_reg || !s_data.frame_end;
    assign accept  = s_valid && s_ready;

    evlhp_field_capture u_capture (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .in_word     (s_data),
        .fields_next (fields_next),
        .byte_count  (byte_count)
    );

    evlhp_summary u_summary (
        .fields     (fields_next),
        .byte_count (byte_count),
        .http_port  (http_port_reg),
        .http_flags (http_flags_reg),
        .summary    (summary)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            http_port_reg  <= HTTP_PORT_RESET;
            http_flags_reg <= HTTP_FLAGS_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_HTTP_PORT:  http_port_reg  <= cfg_wdata;
                CFG_HTTP_FLAGS: http_flags_reg <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept && s_data.frame_end) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_data.frame_end) begin
            m_data_reg <= summary;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: rtl/evlhp_field_capture.sv
// Per-frame byte offset and header field registers of the parser.
// Depends on evlhp_pkg.
module evlhp_field_capture (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    accept,
    input  evlhp_pkg::in_word_t     in_word,
    output evlhp_pkg::frame_fields_t fields_next,
    output logic [6:0]              byte_count
);
    import evlhp_pkg::*;

    logic [5:0]    offset_reg;
    logic [5:0]    offset_next;
    frame_fields_t fields_reg;
    logic          has_tag;
    logic [5:0]    ip_base;
    logic [5:0]    rel;
    logic [7:0]    b;

    assign b       = in_word.frame_byte;
    assign has_tag = (fields_reg.outer_type == ETH_VLAN);
    assign ip_base = has_tag ? 6'd18 : 6'd14;
    assign rel     = offset_reg - ip_base;

    always_comb begin
        fields_next = fields_reg;
        if (offset_reg == 6'd12 || offset_reg == 6'd13) begin
            fields_next.outer_type = {fields_reg.outer_type[7:0], b};
        end else if (offset_reg >= 6'd14) begin
            if (has_tag && (offset_reg == 6'd14 || offset_reg == 6'd15)) begin
                fields_next.tag_word = {fields_reg.tag_word[7:0], b};
            end else if (has_tag && (offset_reg == 6'd16 || offset_reg == 6'd17)) begin
                fields_next.inner_type = {fields_reg.inner_type[7:0], b};
            end else if (offset_reg >= ip_base) begin
                if (rel == 6'd9) begin
                    fields_next.protocol = b;
                end else if (rel >= 6'd12 && rel <= 6'd15) begin
                    fields_next.src_addr = {fields_reg.src_addr[23:0], b};
                end else if (rel >= 6'd16 && rel <= 6'd19) begin
                    fields_next.dst_addr = {fields_reg.dst_addr[23:0], b};
                end else if (rel == 6'd20 || rel == 6'd21) begin
                    fields_next.sport = {fields_reg.sport[7:0], b};
                end else if (rel == 6'd22 || rel == 6'd23) begin
                    fields_next.dport = {fields_reg.dport[7:0], b};
                end else if (rel == 6'd33) begin
                    fields_next.flags = b;
                end
            end
        end
    end

    assign offset_next = (offset_reg < OFFSET_MAX) ? offset_reg + 6'd1 : OFFSET_MAX;
    assign byte_count  = {1'b0, offset_reg} + 7'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= '0;
            fields_reg <= '0;
        end else if (accept) begin
            if (in_word.frame_end) begin
                offset_reg <= '0;
                fields_reg <= '0;
            end else begin
                offset_reg <= offset_next;
                fields_reg <= fields_next;
            end
        end
    end

endmodule

FILE: rtl/evlhp_summary.sv
// Builds the frame summary word from the captured header fields.
// Depends on evlhp_pkg.
module evlhp_summary (
    input  evlhp_pkg::frame_fields_t fields,
    input  logic [6:0]               byte_count,
    input  logic [15:0]              http_port,
    input  logic [7:0]               http_flags,
    output evlhp_pkg::out_word_t     summary
);
    import evlhp_pkg::*;

    logic        has_tag;
    logic [6:0]  ip_base;
    logic [15:0] et;

    assign has_tag = (fields.outer_type == ETH_VLAN);
    assign ip_base = has_tag ? 7'd18 : 7'd14;
    assign et      = has_tag ? fields.inner_type : fields.outer_type;

    always_comb begin
        summary = '0;
        if (byte_count < ip_base) begin
            summary.status = ST_TRUNCATED;
        end else if (et != ETH_IPV4) begin
            summary.ether_type = et;
            summary.status     = ST_OTHER_TYPE;
        end else if (byte_count < ip_base + 7'd20) begin
            summary.status = ST_TRUNCATED;
        end else if (fields.protocol == PROTO_TCP && byte_count < ip_base + 7'd40) begin
            summary.status = ST_TRUNCATED;
        end else if (fields.protocol == PROTO_UDP && byte_count < ip_base + 7'd28) begin
            summary.status = ST_TRUNCATED;
        end else begin
            summary.ether_type          = et;
            summary.ip_protocol         = fields.protocol;
            summary.source_address      = fields.src_addr;
            summary.destination_address = fields.dst_addr;
            if (fields.protocol == PROTO_TCP) begin
                summary.source_port      = fields.sport;
                summary.destination_port = fields.dport;
                summary.tcp_flag_bits    = fields.flags;
                if (!has_tag && fields.flags == http_flags && fields.dport == http_port) begin
                    summary.status = ST_HTTP;
                end else begin
                    summary.status = ST_TCP;
                end
            end else if (fields.protocol == PROTO_UDP) begin
                summary.source_port      = fields.sport;
                summary.destination_port = fields.dport;
                summary.status           = ST_UDP;
            end else begin
                summary.status = ST_IPV4_OTHER;
            end
        end
        if (summary.status != ST_TRUNCATED && has_tag) begin
            summary.vlan_tagged   = 1'b1;
            summary.vlan_priority = fields.tag_word[15:13];
            summary.vlan_cfi      = fields.tag_word[12];
            summary.vlan_id       = fields.tag_word[11:0];
        end
    end

endmodule

FILE: rtl/evlhp_checker.sv
// Port-level checks of the header parser, bound to the top level.
// Depends on evlhp_pkg and ethernet_vlan_ipv4_l4_header_parser_defines.svh.
`include "ethernet_vlan_ipv4_l4_header_parser_defines.svh"

module evlhp_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input evlhp_pkg::in_word_t  s_data,
    input logic                 m_valid,
    input logic                 m_ready,
    input evlhp_pkg::out_word_t m_data
);
    import evlhp_pkg::*;

    `EVLHP_ASSERT_CLK(a_out_hold, aclk, aresetn,
        m_valid && !m_ready |=> m_valid && $stable(m_data))

    `EVLHP_ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> !m_valid)

    `EVLHP_ASSERT_CLK(a_word_from_end, aclk, aresetn,
        $rose(m_valid) |-> $past(s_valid && s_ready && s_data.frame_end))

    `EVLHP_ASSERT_CLK(a_truncated_empty, aclk, aresetn,
        m_valid && m_data.status == ST_TRUNCATED |->
            m_data.ether_type == 16'd0 && !m_data.vlan_tagged &&
            m_data.source_address == 32'd0 && m_data.source_port == 16'd0)

endmodule

bind ethernet_vlan_ipv4_l4_header_parser evlhp_checker u_evlhp_checker (.*);

FILE: sim/tb_ethernet_vlan_ipv4_l4_header_parser.sv
// Testbench for ethernet_vlan_ipv4_l4_header_parser: streams framed bytes, predicts each
// frame summary and compares it field by field. Depends on evlhp_pkg and the parser RTL.
`timescale 1ns / 1ps

module tb_ethernet_vlan_ipv4_l4_header_parser;
    import evlhp_pkg::*;

    localparam int          FRAME_MAX   = 128;
    localparam int          STALL_LIMIT = 3000;
    localparam logic [15:0] ETH_IPV6    = 16'h86DD;
    localparam logic [7:0]  PROTO_ICMP  = 8'h01;

    class frame_summary_checker;
        logic [15:0]   http_port;
        logic [7:0]    http_flags;
        logic [5:0]    offset;
        frame_fields_t fields;
        out_word_t     pending_summaries[$];
        int            errors;
        int            summary_count;

        function new();
            http_port = HTTP_PORT_RESET;
            http_flags = HTTP_FLAGS_RESET;
            errors = 0;
            summary_count = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            offset = '0;
            fields = '0;
        endfunction

        function void capture(logic [5:0] off, logic [7:0] b);
            int ip_start;
            int r;
            if (off == 12 || off == 13) begin
                fields.outer_type = {fields.outer_type[7:0], b};
                return;
            end
            if (off < 14) return;
            if (fields.outer_type == ETH_VLAN) begin
                if (off == 14 || off == 15) begin
                    fields.tag_word = {fields.tag_word[7:0], b};
                    return;
                end
                if (off == 16 || off == 17) begin
                    fields.inner_type = {fields.inner_type[7:0], b};
                    return;
                end
                ip_start = 18;
            end else begin
                ip_start = 14;
            end
            if (off < ip_start) return;
            r = off - ip_start;
            if (r == 9) fields.protocol = b;
            else if (r >= 12 && r <= 15) fields.src_addr = {fields.src_addr[23:0], b};
            else if (r >= 16 && r <= 19) fields.dst_addr = {fields.dst_addr[23:0], b};
            else if (r == 20 || r == 21) fields.sport = {fields.sport[7:0], b};
            else if (r == 22 || r == 23) fields.dport = {fields.dport[7:0], b};
            else if (r == 33) fields.flags = b;
        endfunction

        function out_word_t predict_summary(int count);
            out_word_t   s;
            logic        has_tag;
            int          ip_start;
            logic [15:0] etype;
            s = '0;
            has_tag = (fields.outer_type == ETH_VLAN);
            ip_start = has_tag ? 18 : 14;
            if (count < ip_start) begin
                s.status = ST_TRUNCATED;
                return s;
            end
            etype = has_tag ? fields.inner_type : fields.outer_type;
            s.status = ST_OTHER_TYPE;
            if (etype == ETH_IPV4) begin
                if (count < ip_start + 20) begin
                    s.status = ST_TRUNCATED;
                    return s;
                end
                if (fields.protocol == PROTO_TCP) begin
                    if (count < ip_start + 40) begin
                        s.status = ST_TRUNCATED;
                        return s;
                    end
                    s.status = (!has_tag && fields.flags == http_flags
                                && fields.dport == http_port) ? ST_HTTP : ST_TCP;
                    s.source_port = fields.sport;
                    s.destination_port = fields.dport;
                    s.tcp_flag_bits = fields.flags;
                end else if (fields.protocol == PROTO_UDP) begin
                    if (count < ip_start + 28) begin
                        s.status = ST_TRUNCATED;
                        return s;
                    end
                    s.status = ST_UDP;
                    s.source_port = fields.sport;
                    s.destination_port = fields.dport;
                end else begin
                    s.status = ST_IPV4_OTHER;
                end
                s.ip_protocol = fields.protocol;
                s.source_address = fields.src_addr;
                s.destination_address = fields.dst_addr;
            end
            s.ether_type = etype;
            if (has_tag) begin
                s.vlan_tagged = 1'b1;
                s.vlan_priority = fields.tag_word[15:13];
                s.vlan_cfi = fields.tag_word[12];
                s.vlan_id = fields.tag_word[11:0];
            end
            return s;
        endfunction

        function void note_byte(in_word_t w);
            logic [5:0] off;
            off = offset;
            capture(off, w.frame_byte);
            if (w.frame_end) begin
                pending_summaries.push_back(predict_summary(int'(off) + 1));
                clear_frame();
            end else if (off != OFFSET_MAX) begin
                offset = off + 6'd1;
            end
        endfunction

        task report(string msg);
            // limit log volume
            if (errors < 100) $display("MISMATCH summary %0d: %s", summary_count, msg);
            errors++;
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want) report($sformatf("%s got %h want %h", name, got, want));
        endtask

        task check_summary(out_word_t got);
            out_word_t want;
            if (pending_summaries.size() == 0) begin
                report($sformatf("unexpected word %h", got));
                return;
            end
            want = pending_summaries.pop_front();
            compare_field("ether_type", got.ether_type, want.ether_type);
            compare_field("vlan_tagged", got.vlan_tagged, want.vlan_tagged);
            compare_field("vlan_priority", got.vlan_priority, want.vlan_priority);
            compare_field("vlan_cfi", got.vlan_cfi, want.vlan_cfi);
            compare_field("vlan_id", got.vlan_id, want.vlan_id);
            compare_field("ip_protocol", got.ip_protocol, want.ip_protocol);
            compare_field("source_address", got.source_address, want.source_address);
            compare_field("destination_address", got.destination_address,
                          want.destination_address);
            compare_field("source_port", got.source_port, want.source_port);
            compare_field("destination_port", got.destination_port, want.destination_port);
            compare_field("tcp_flag_bits", got.tcp_flag_bits, want.tcp_flag_bits);
            compare_field("status", got.status, want.status);
            summary_count++;
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_word_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_word_t   m_data;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_index = CFG_HTTP_PORT;
    logic [15:0] cfg_wdata = '0;

    frame_summary_checker checker_h;
    logic [7:0]  frame_buf[0:FRAME_MAX-1];
    int          phase_bytes;
    int          phase_frames;
    int          sink_hold = 0;
    int          stall_count = 0;

    ethernet_vlan_ipv4_l4_header_parser DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_count <= 0;
        end else begin
            stall_count <= stall_count + 1;
        end
        if (stall_count >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last, input int gap);
        in_word_t w;
        w.frame_byte = b;
        w.frame_end = last;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        checker_h.note_byte(w);
        @(negedge aclk);
    endtask

    task automatic put_frame(input bit has_tag, input logic [15:0] etype,
                             input logic [7:0] proto, input bit http,
                             input int length, input int fill);
        int i;
        int ip_start;
        bit burst;
        for (i = 0; i < FRAME_MAX; i++) frame_buf[i] = (fill < 0) ? 8'($urandom) : 8'(fill);
        ip_start = has_tag ? 18 : 14;
        if (has_tag) begin
            {frame_buf[12], frame_buf[13]} = ETH_VLAN;
            {frame_buf[16], frame_buf[17]} = etype;
        end else begin
            {frame_buf[12], frame_buf[13]} = etype;
        end
        frame_buf[ip_start + 9] = proto;
        if (http) begin
            {frame_buf[ip_start + 22], frame_buf[ip_start + 23]} = checker_h.http_port;
            frame_buf[ip_start + 33] = checker_h.http_flags;
        end
        burst = ($urandom_range(0, 3) == 0);
        for (i = 0; i < length; i++) begin
            send_byte(frame_buf[i], i == length - 1, burst ? 0 : $urandom_range(0, 9));
        end
        phase_bytes += length;
        phase_frames++;
    endtask

    task automatic random_frame();
        int          pick;
        int          needed;
        int          length;
        bit          has_tag;
        bit          http;
        logic [15:0] etype;
        logic [7:0]  proto;
        pick = $urandom_range(0, 99);
        has_tag = ($urandom_range(0, 3) == 0);
        etype = ($urandom_range(0, 4) != 0) ? ETH_IPV4 : 16'($urandom);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: proto = PROTO_TCP;
            4, 5, 6: proto = PROTO_UDP;
            default: proto = 8'($urandom);
        endcase
        http = !has_tag && proto == PROTO_TCP && $urandom_range(0, 1);
        needed = has_tag ? 18 : 14;
        if (etype == ETH_IPV4) begin
            needed += 20;
            if (proto == PROTO_TCP) needed += 20;
            else if (proto == PROTO_UDP) needed += 8;
        end
        if (pick < 65) begin
            length = needed + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 40)
                                                             : $urandom_range(0, 3));
        end else if (pick < 85) begin
            length = $urandom_range(1, needed - 1);
        end else begin
            etype = 16'($urandom);
            proto = 8'($urandom);
            length = $urandom_range(1, 80);
        end
        put_frame(has_tag, etype, proto, http, length, -1);
    endtask

    task automatic run_random();
        phase_bytes = 0;
        phase_frames = 0;
        while (phase_bytes < 190 || phase_frames < 5) random_frame();
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (checker_h.pending_summaries.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic set_http_match(input logic [15:0] port, input logic [7:0] flags);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_HTTP_PORT;
        cfg_wdata <= port;
        @(negedge aclk);
        cfg_index <= CFG_HTTP_FLAGS;
        cfg_wdata <= {8'($urandom), flags};
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        checker_h.http_port = port;
        checker_h.http_flags = flags;
    endtask

    task automatic run_sink();
        int delay;
        int quiet_left;
        quiet_left = 0;
        forever begin
            @(negedge aclk);
            if (sink_hold > 0) begin
                delay = sink_hold;
                sink_hold = 0;
            end else if (quiet_left > 0) begin
                delay = 0;
                quiet_left--;
            end else if ($urandom_range(0, 4) == 0) begin
                delay = 0;
                quiet_left = $urandom_range(1, 10);
            end else begin
                delay = $urandom_range(0, 9);
            end
            if (delay > 0) begin
                m_ready <= 1'b0;
                repeat (delay) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            checker_h.check_summary(m_data);
        end
    endtask

    task automatic run_directed();
        put_frame(0, ETH_IPV6, 8'h00, 0, 1, -1);
        put_frame(0, ETH_IPV6, 8'h00, 0, 13, -1);
        put_frame(0, ETH_IPV6, 8'h00, 0, 14, -1);
        put_frame(1, ETH_IPV4, PROTO_TCP, 0, 17, -1);
        put_frame(0, ETH_IPV4, PROTO_ICMP, 0, 34, -1);
        put_frame(0, ETH_IPV4, PROTO_ICMP, 0, 33, -1);
        put_frame(0, ETH_IPV4, PROTO_TCP, 1, 54, -1);
        put_frame(0, ETH_IPV4, PROTO_TCP, 0, 54, 0);
        put_frame(0, ETH_IPV4, PROTO_TCP, 1, 53, -1);
        put_frame(1, ETH_IPV4, PROTO_TCP, 1, 58, -1);
        put_frame(1, ETH_IPV4, PROTO_TCP, 0, 58, 8'hFF);
        put_frame(0, ETH_IPV4, PROTO_UDP, 0, 42, -1);
        put_frame(0, ETH_IPV4, PROTO_UDP, 0, 41, -1);
        put_frame(1, ETH_IPV4, PROTO_UDP, 0, 46, 0);
        put_frame(0, ETH_IPV4, PROTO_TCP, 1, 100, -1);
        put_frame(1, 16'hFFFF, 8'hFF, 0, 18, 8'hFF);
        put_frame(0, ETH_IPV4, 8'hFF, 0, 80, -1);
        put_frame(1, ETH_VLAN, 8'h00, 0, 30, -1);
    endtask

    initial begin
        checker_h = new();
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        fork
            run_sink();
        join_none
        @(negedge aclk);

        run_directed();
        run_random();
        drain();

        set_http_match(16'h0000, 8'h00);
        run_random();
        drain();

        // stall the result side long enough to back up the input
        sink_hold = 400;
        set_http_match(16'hFFFF, 8'hFF);
        run_random();
        drain();

        set_http_match(16'($urandom), 8'($urandom));
        run_random();
        drain();

        set_http_match(HTTP_PORT_RESET, HTTP_FLAGS_RESET);
        run_random();
        drain();

        if (checker_h.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
